// ===== design/bgc_pkg.sv =====
// Shared types, register codes and helper functions of the button gesture classifier.
package bgc_pkg;

  localparam int TickWidth  = 24;
  localparam int LevelWidth = 8;
  localparam int DutyWidth  = 7;
  localparam int BlinkWidth = 9;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 24;

  localparam logic [TickWidth-1:0]  TickMax  = {TickWidth{1'b1}};
  localparam logic [BlinkWidth-1:0] BlinkMax = {BlinkWidth{1'b1}};
  localparam logic [DutyWidth-1:0]  DutyFull = 7'd100;
  localparam logic [LevelWidth-1:0] RedReset = 8'd255;

  typedef logic [TickWidth-1:0]  tick_t;
  typedef logic [LevelWidth-1:0] level_t;
  typedef logic [DutyWidth-1:0]  duty_t;
  typedef logic [BlinkWidth-1:0] blink_cnt_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } mode_event_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MODE_LONG = 3'd0,
    REG_MODE_IDLE = 3'd1,
    REG_PAIR_LONG = 3'd2,
    REG_BLINK     = 3'd3,
    REG_RED       = 3'd4,
    REG_GREEN     = 3'd5,
    REG_BLUE      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    tick_t long_ticks;
    tick_t idle_ticks;
  } mode_cfg_t;

  typedef struct packed {
    level_t period;
    level_t red;
    level_t green;
    level_t blue;
  } led_cfg_t;

  typedef struct packed {
    logic  lit;
    duty_t red;
    duty_t green;
    duty_t blue;
  } led_out_t;

  function automatic tick_t sat_tick(tick_t v);
    return (v == TickMax) ? v : v + tick_t'(1);
  endfunction

  // Inverted duty 100 - level*100/255; the division by 255 uses the
  // reciprocal form (x + (x >> 8) + 1) >> 8, exact for x below 65535.
  function automatic duty_t duty_of(level_t level);
    logic [15:0] prod;
    logic [15:0] quot;
    prod = {8'd0, level} * 16'd100;
    quot = (prod + (prod >> 8) + 16'd1) >> 8;
    return DutyFull - quot[DutyWidth-1:0];
  endfunction

endpackage

// ===== design/bgc_in_if.sv =====
// Input channel interface carrying the three raw button pins of one tick.
interface bgc_in_if;
  logic valid;
  logic ready;
  logic up_pin;
  logic down_pin;
  logic mode_pin;

  modport source (output valid, output up_pin, output down_pin, output mode_pin,
                  input ready);
  modport sink   (input valid, input up_pin, input down_pin, input mode_pin,
                  output ready);
endinterface

// ===== design/bgc_out_if.sv =====
// Output channel interface carrying the classified result of one tick.
interface bgc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 up_pressed;
  logic                 down_pressed;
  logic                 mode_pressed;
  logic [1:0]           mode_event;
  logic                 pair_event;
  logic                 led_lit;
  bgc_pkg::duty_t       red_duty;
  bgc_pkg::duty_t       green_duty;
  bgc_pkg::duty_t       blue_duty;

  modport source (output valid, output up_pressed, output down_pressed,
                  output mode_pressed, output mode_event, output pair_event,
                  output led_lit, output red_duty, output green_duty,
                  output blue_duty, input ready);
  modport sink   (input valid, input up_pressed, input down_pressed,
                  input mode_pressed, input mode_event, input pair_event,
                  input led_lit, input red_duty, input green_duty,
                  input blue_duty, output ready);
endinterface

// ===== design/bgc_mode.sv =====
// Mode button classifier: short, double and long press detection.
module bgc_mode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 mode,
  input  bgc_pkg::mode_cfg_t   cfg,
  output bgc_pkg::mode_event_t mode_event
);

  logic           mode_was_pressed, mode_was_pressed_next;
  logic           long_seen, long_seen_next;
  logic [1:0]     release_count, release_count_next;
  bgc_pkg::tick_t held_elapsed, held_elapsed_next;
  bgc_pkg::tick_t idle_elapsed, idle_elapsed_next;

  always_comb begin
    logic           released;
    logic [1:0]     count_step;
    bgc_pkg::tick_t held_base;
    released   = !mode && mode_was_pressed && !long_seen;
    held_base  = (mode && !mode_was_pressed) ? '0 : bgc_pkg::sat_tick(held_elapsed);
    count_step = (release_count == 2'd3) ? release_count : release_count + 2'd1;

    mode_event            = bgc_pkg::EV_NONE;
    held_elapsed_next     = held_base;
    long_seen_next        = (!mode && mode_was_pressed) ? 1'b0 : long_seen;
    release_count_next    = released ? count_step : release_count;
    idle_elapsed_next     = released ? '0 : bgc_pkg::sat_tick(idle_elapsed);
    mode_was_pressed_next = mode;

    if (mode) begin
      if (held_base > cfg.long_ticks) begin
        mode_event        = bgc_pkg::EV_LONG;
        held_elapsed_next = '0;
        long_seen_next    = 1'b1;
      end
    end else if (release_count_next != 2'd0 && idle_elapsed_next > cfg.idle_ticks) begin
      case (release_count_next)
        2'd1:    mode_event = bgc_pkg::EV_SHORT;
        2'd2:    mode_event = bgc_pkg::EV_DOUBLE;
        default: release_count_next = 2'd0;
      endcase
    end
    if (mode_event != bgc_pkg::EV_NONE) begin
      release_count_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_was_pressed <= 1'b0;
      long_seen        <= 1'b0;
      release_count    <= 2'd0;
      held_elapsed     <= '0;
      idle_elapsed     <= '0;
    end else if (step) begin
      mode_was_pressed <= mode_was_pressed_next;
      long_seen        <= long_seen_next;
      release_count    <= release_count_next;
      held_elapsed     <= held_elapsed_next;
      idle_elapsed     <= idle_elapsed_next;
    end
  end

  a_long_sets_seen: assert property (@(posedge clk) disable iff (rst)
    step && mode_event == bgc_pkg::EV_LONG |=> long_seen && held_elapsed == '0)
    else $error("Long press did not set long_seen and restart the hold counter.");

  a_event_clears_count: assert property (@(posedge clk) disable iff (rst)
    step && mode_event != bgc_pkg::EV_NONE |=> release_count == 2'd0)
    else $error("Mode event did not clear the release count.");

endmodule

// ===== design/bgc_pair.sv =====
// Up plus down pair detector with repeating long press.
module bgc_pair (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           up,
  input  logic           down,
  input  bgc_pkg::tick_t long_ticks,
  output logic           pair_event
);

  logic           up_was_pressed, down_was_pressed;
  bgc_pkg::tick_t held_elapsed, held_elapsed_next;

  always_comb begin
    bgc_pkg::tick_t held_base;
    held_base = (!up_was_pressed || !down_was_pressed) ? '0
                                                       : bgc_pkg::sat_tick(held_elapsed);
    pair_event        = 1'b0;
    held_elapsed_next = bgc_pkg::sat_tick(held_elapsed);
    if (up && down) begin
      held_elapsed_next = held_base;
      if (held_base > long_ticks) begin
        pair_event        = 1'b1;
        held_elapsed_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_was_pressed   <= 1'b0;
      down_was_pressed <= 1'b0;
      held_elapsed     <= '0;
    end else if (step) begin
      up_was_pressed   <= up;
      down_was_pressed <= down;
      held_elapsed     <= held_elapsed_next;
    end
  end

endmodule

// ===== design/bgc_led.sv =====
// Blink divider and inverted PWM duty levels of the status LED.
module bgc_led (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              clear,
  input  bgc_pkg::led_cfg_t cfg,
  output bgc_pkg::led_out_t led
);

  bgc_pkg::blink_cnt_t blink_count, blink_count_next;
  logic                blink_on, blink_on_next;

  always_comb begin
    bgc_pkg::blink_cnt_t cnt_mid;
    cnt_mid       = blink_count;
    blink_on_next = blink_on;
    if (cfg.period == '0) begin
      blink_on_next = 1'b1;
    end else if (blink_count > {1'b0, cfg.period}) begin
      cnt_mid       = '0;
      blink_on_next = !blink_on;
    end
    blink_count_next = (cnt_mid == bgc_pkg::BlinkMax) ? cnt_mid
                                                      : cnt_mid + bgc_pkg::blink_cnt_t'(1);

    led.lit   = blink_on_next;
    led.red   = blink_on_next ? bgc_pkg::duty_of(cfg.red)   : bgc_pkg::DutyFull;
    led.green = blink_on_next ? bgc_pkg::duty_of(cfg.green) : bgc_pkg::DutyFull;
    led.blue  = blink_on_next ? bgc_pkg::duty_of(cfg.blue)  : bgc_pkg::DutyFull;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_count <= '0;
      blink_on    <= 1'b1;
    end else if (clear) begin
      blink_count <= '0;
    end else if (step) begin
      blink_count <= blink_count_next;
      blink_on    <= blink_on_next;
    end
  end

endmodule

// ===== design/button_gesture_classifier_unit.sv =====
// Top level of the button gesture classifier: configuration, sub-units and result register.
// Each result is registered in the output register at the clock edge that accepts its input transaction.
// Throughput: one input transaction per cycle while the output side is ready; all work sits between the input
// port and the result register, which is refilled in the same cycle it drains.
// Reset: synchronous active-high rst clears the counters and configuration, sets blink_on and led_cfg.red to
// full and empties the result register; no clearing pass is needed.
module button_gesture_classifier_unit (
  input  logic                                clk,
  input  logic                                rst,
  bgc_in_if.sink                              in_ch,
  bgc_out_if.source                           out_ch,
  input  logic                                cfg_wr_en,
  input  logic [bgc_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [bgc_pkg::CfgDataWidth-1:0]    cfg_data
);

  bgc_pkg::mode_cfg_t   mode_cfg;
  bgc_pkg::tick_t       pair_long_ticks;
  bgc_pkg::led_cfg_t    led_cfg;
  logic                 blink_clear;
  logic                 accept;
  logic                 up, down, mode;
  bgc_pkg::mode_event_t mode_event;
  logic                 pair_event;
  bgc_pkg::led_out_t    led;

  assign up     = !in_ch.up_pin;
  assign down   = !in_ch.down_pin;
  assign mode   = !in_ch.mode_pin;
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_cfg.long_ticks <= '0;
      mode_cfg.idle_ticks <= '0;
      pair_long_ticks     <= '0;
      led_cfg.period      <= '0;
      led_cfg.red         <= bgc_pkg::RedReset;
      led_cfg.green       <= '0;
      led_cfg.blue        <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bgc_pkg::REG_MODE_LONG: mode_cfg.long_ticks <= cfg_data;
        bgc_pkg::REG_MODE_IDLE: mode_cfg.idle_ticks <= cfg_data;
        bgc_pkg::REG_PAIR_LONG: pair_long_ticks     <= cfg_data;
        bgc_pkg::REG_BLINK:     led_cfg.period      <= cfg_data[bgc_pkg::LevelWidth-1:0];
        bgc_pkg::REG_RED:       led_cfg.red         <= cfg_data[bgc_pkg::LevelWidth-1:0];
        bgc_pkg::REG_GREEN:     led_cfg.green       <= cfg_data[bgc_pkg::LevelWidth-1:0];
        bgc_pkg::REG_BLUE:      led_cfg.blue        <= cfg_data[bgc_pkg::LevelWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      bgc_pkg::REG_BLINK, bgc_pkg::REG_RED,
      bgc_pkg::REG_GREEN, bgc_pkg::REG_BLUE: blink_clear = cfg_wr_en;
      default:                               blink_clear = 1'b0;
    endcase
  end

  bgc_mode u_mode (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .mode       (mode),
    .cfg        (mode_cfg),
    .mode_event (mode_event)
  );

  bgc_pair u_pair (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .up         (up),
    .down       (down),
    .long_ticks (pair_long_ticks),
    .pair_event (pair_event)
  );

  bgc_led u_led (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .clear (blink_clear),
    .cfg   (led_cfg),
    .led   (led)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.up_pressed   <= up;
      out_ch.down_pressed <= down;
      out_ch.mode_pressed <= mode;
      out_ch.mode_event   <= mode_event;
      out_ch.pair_event   <= pair_event;
      out_ch.led_lit      <= led.lit;
      out_ch.red_duty     <= led.red;
      out_ch.green_duty   <= led.green;
      out_ch.blue_duty    <= led.blue;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("Accepted transaction did not fill the result register.");

  a_long_while_held: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.mode_event == bgc_pkg::EV_LONG |-> out_ch.mode_pressed)
    else $error("Long press reported while the mode button is up.");

  a_short_while_up: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.mode_event == bgc_pkg::EV_SHORT ||
                     out_ch.mode_event == bgc_pkg::EV_DOUBLE) |-> !out_ch.mode_pressed)
    else $error("Short or double press reported while the mode button is held.");

  a_pair_held: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.pair_event |-> out_ch.up_pressed && out_ch.down_pressed)
    else $error("Pair event reported without both buttons pressed.");

  a_dark_duty: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.led_lit |-> out_ch.red_duty == bgc_pkg::DutyFull &&
      out_ch.green_duty == bgc_pkg::DutyFull && out_ch.blue_duty == bgc_pkg::DutyFull)
    else $error("LED blinked off but a duty level is not dark.");

endmodule
